@@ design/itrt_pkg.sv @@
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared types, constants and the digit-to-ASCII mapping for the radix text
// converter.
// ----------------------------------------------------------------------------
package itrt_pkg;

    localparam int STEP_BITS = 8;

    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] RADIX_RESET = 6'd16;

    localparam logic [5:0] DIGIT_NINE  = 6'd9;
    localparam logic [5:0] DIGIT_TEN   = 6'd10;

    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;

    localparam logic REG_SEL_RADIX = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_SIGN_OUT,
        ST_FETCH,
        ST_LOAD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic resume;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
        logic quot_zero;
    } div_stat_t;

    function automatic logic [7:0] digit_glyph(input logic [5:0] d);
        logic [7:0] g;
        if (d <= DIGIT_NINE) begin
            g = CHAR_ZERO + {2'b00, d};
        end else begin
            g = CHAR_UPPER_A + {2'b00, d - DIGIT_TEN};
        end
        return g;
    endfunction

endpackage

@@ design/itrt_ram.sv @@
// ----------------------------------------------------------------------------
// itrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itrt_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/itrt_cfg.sv @@
// ----------------------------------------------------------------------------
// itrt_cfg
// APB register port holding the conversion base, saturated to 2..36.
// ----------------------------------------------------------------------------
module itrt_cfg
    import itrt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [5:0]  radix
);

    logic [5:0] radix_reg;
    logic [5:0] radix_next;
    logic [5:0] wr_val;
    logic       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_SEL_RADIX);
    assign wr_val = pwdata[5:0];

    always_comb begin
        radix_next = radix_reg;
        if (wr_hit) begin
            if (wr_val < RADIX_MIN) begin
                radix_next = RADIX_MIN;
            end else if (wr_val > RADIX_MAX) begin
                radix_next = RADIX_MAX;
            end else begin
                radix_next = wr_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else begin
            radix_reg <= radix_next;
        end
    end

    assign prdata = (paddr[2] == REG_SEL_RADIX) ? {26'd0, radix_reg} : 32'd0;
    assign radix  = radix_reg;

endmodule

@@ design/itrt_div_unit.sv @@
// ----------------------------------------------------------------------------
// itrt_div_unit
// Shared long divider by a small base: STEP_BITS quotient bits per cycle,
// leaving the quotient in place and the remainder as the next digit.
// ----------------------------------------------------------------------------
module itrt_div_unit
    import itrt_pkg::*;
#(
    parameter int PAD_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  div_ctrl_t           ctrl,
    input  logic [PAD_BITS-1:0] load_mag,
    input  logic [5:0]          base,
    output div_stat_t           stat,
    output logic [5:0]          digit
);

    localparam int CHUNKS = PAD_BITS / STEP_BITS;
    localparam int KW     = $clog2(CHUNKS + 1);

    logic [PAD_BITS-1:0]  dvd_reg;
    logic [PAD_BITS-1:0]  dvd_next;
    logic [5:0]           rem_reg;
    logic [5:0]           rem_next;
    logic [KW-1:0]        cnt_reg;
    logic [KW-1:0]        cnt_next;
    logic                 done_reg;
    logic                 done_next;
    logic [6:0]           r;
    logic [STEP_BITS-1:0] q;

    always_comb begin
        r = {1'b0, rem_reg};
        q = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            r = {r[5:0], dvd_reg[PAD_BITS-1-i]};
            if (r >= {1'b0, base}) begin
                r = r - {1'b0, base};
                q[STEP_BITS-1-i] = 1'b1;
            end
        end
    end

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (ctrl.start || ctrl.resume) begin
            if (ctrl.start) begin
                dvd_next = load_mag;
            end
            rem_next = '0;
            cnt_next = KW'(CHUNKS);
        end else if (cnt_reg != '0) begin
            dvd_next  = (dvd_reg << STEP_BITS) | PAD_BITS'(q);
            rem_next  = r[5:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == KW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            dvd_reg  <= dvd_next;
            rem_reg  <= rem_next;
        end
    end

    assign stat.done      = done_reg;
    assign stat.quot_zero = (dvd_reg == '0);
    assign digit          = rem_reg;

endmodule

@@ design/integer_to_radix_text.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_text
// Signed integer to ASCII text in a programmable base, one character per
// output transfer, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed WORD_BITS-bit value per request; s_axis_tready
//   is high only while the block is idle. m_axis returns the text: a '-' for
//   negative values, then the digits '0'-'9', 'A'-'Z'; tlast marks the final
//   character. The APB register at address 0 sets the base (2..36, saturated,
//   reset 16); write it only while idle.
//   Timing: each digit is one pass of the shared divider, which retires
//   8 quotient bits per cycle. Each character then passes through the
//   digit RAM read and the output register and waits while the receiver
//   stalls; a sign goes straight into the output register.
//   A stalled receiver holds the current character; no further work happens
//   until it is taken. Reset empties the output and returns to idle with the
//   base at 16.
// ----------------------------------------------------------------------------
module integer_to_radix_text
    import itrt_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // [WORD_BITS-1:0] value
    input  logic [((WORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] out_char
    output logic [7:0]                          m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int PAD_BITS = ((WORD_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int AW       = $clog2(WORD_BITS);
    localparam int CW       = $clog2(WORD_BITS + 1);

    state_t         state_reg;
    state_t         state_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic [AW-1:0]  idx_reg;
    logic [AW-1:0]  idx_next;
    logic           neg_reg;
    logic           neg_next;
    logic           m_valid_reg;
    logic           m_valid_next;
    logic [7:0]     m_data_reg;
    logic [7:0]     m_data_next;
    logic           m_last_reg;
    logic           m_last_next;

    logic [5:0]           radix;
    div_ctrl_t            div_ctrl;
    div_stat_t            div_stat;
    logic [5:0]           digit;
    logic [5:0]           rd_digit;
    logic                 ram_we;
    logic [WORD_BITS-1:0] in_value;
    logic [WORD_BITS-1:0] in_mag;
    logic                 s_req;
    logic                 m_req;

    assign in_value = s_axis_tdata[WORD_BITS-1:0];
    assign in_mag   = in_value[WORD_BITS-1] ? (~in_value + 1'b1) : in_value;
    assign s_req    = s_axis_tvalid && (state_reg == ST_IDLE);
    assign m_req    = m_valid_reg && m_axis_tready;

    itrt_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .radix   (radix)
    );

    itrt_div_unit #(
        .PAD_BITS (PAD_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .load_mag (PAD_BITS'(in_mag)),
        .base     (radix),
        .stat     (div_stat),
        .digit    (digit)
    );

    itrt_ram #(
        .WIDTH (6),
        .DEPTH (WORD_BITS)
    ) u_digits (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (digit),
        .raddr (idx_reg),
        .rdata (rd_digit)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_req) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done && div_stat.quot_zero) begin
                    state_next = neg_reg ? ST_SIGN : ST_FETCH;
                end
            end
            ST_SIGN:     state_next = ST_SIGN_OUT;
            ST_SIGN_OUT: begin
                if (m_req) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:    state_next = ST_LOAD;
            ST_LOAD:     state_next = ST_OUT;
            ST_OUT: begin
                if (m_req) begin
                    state_next = (idx_reg == '0) ? ST_IDLE : ST_FETCH;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        neg_next        = neg_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        div_ctrl.start  = 1'b0;
        div_ctrl.resume = 1'b0;
        ram_we          = 1'b0;
        s_axis_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_req) begin
                    neg_next       = in_value[WORD_BITS-1];
                    cnt_next       = '0;
                    div_ctrl.start = 1'b1;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    ram_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (div_stat.quot_zero) begin
                        idx_next = cnt_reg[AW-1:0];
                    end else begin
                        div_ctrl.resume = 1'b1;
                    end
                end
            end
            ST_SIGN: begin
                m_data_next  = CHAR_MINUS;
                m_last_next  = 1'b0;
                m_valid_next = 1'b1;
            end
            ST_SIGN_OUT: begin
                if (m_req) begin
                    m_valid_next = 1'b0;
                end
            end
            ST_FETCH: begin
            end
            ST_LOAD: begin
                m_data_next  = digit_glyph(rd_digit);
                m_last_next  = (idx_reg == '0);
                m_valid_next = 1'b1;
            end
            ST_OUT: begin
                if (m_req) begin
                    m_valid_next = 1'b0;
                    if (idx_reg != '0) begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            neg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            neg_reg     <= neg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tvalid = m_valid_reg;

endmodule

@@ dv/tb_integer_to_radix_text.sv @@
// ----------------------------------------------------------------------------
// tb_integer_to_radix_text
// Self-checking bench for the radix text converter. A directed table covers
// the base extremes, saturating base writes, a write to an unused address,
// zero, the word extremes and the most negative value; random phases then
// sweep many bases with mixed values. Each character request is checked
// against table text or a bench digit splitter; both streams idle randomly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_integer_to_radix_text
    import itrt_pkg::*;
;

    localparam logic [2:0] RADIX_ADDR  = 3'd0;
    localparam logic [2:0] UNUSED_ADDR = 3'd4;
    localparam int PHASES          = 10;
    localparam int VALUES_PER_PHASE = 47;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int TAIL_CYCLES     = 40;

    typedef enum logic { ROW_VALUE, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  addr;
        logic [31:0] data;
        string       text;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } text_char_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [5:0]  radix_now = RADIX_RESET;
    text_char_t  expected_chars[$];
    stim_row_t   directed_rows[$];
    int          errors       = 0;
    int          stall_cycles = 0;
    bit          no_idle      = 1'b0;

    integer_to_radix_text #(
        .WORD_BITS(32)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] value
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_char
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] c;
        if (d <= DIGIT_NINE) begin
            c = CHAR_ZERO + 8'(d);
        end else begin
            c = CHAR_UPPER_A + 8'(d - DIGIT_TEN);
        end
        return c;
    endfunction

    function automatic void predict_text(input logic [31:0] v, input logic [5:0] base);
        logic [31:0] mag;
        logic [5:0]  digits[32];
        int          n;
        text_char_t  c;
        n   = 0;
        mag = v[31] ? (~v + 32'd1) : v;
        do begin
            digits[n] = 6'(mag % 32'(base));
            n++;
            mag = mag / 32'(base);
        end while (mag != 0);
        if (v[31]) begin
            c.out_char  = CHAR_MINUS;
            c.last_char = 1'b0;
            expected_chars.push_back(c);
        end
        for (int k = n - 1; k >= 0; k--) begin
            c.out_char  = digit_char(digits[k]);
            c.last_char = (k == 0);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic logic [5:0] clamp_radix(input logic [31:0] data);
        logic [5:0] r;
        r = data[5:0];
        if (r < RADIX_MIN) r = RADIX_MIN;
        if (r > RADIX_MAX) r = RADIX_MAX;
        return r;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        longint      p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom();
            4: v = $urandom_range(0, 40);
            5: v = -32'($urandom_range(1, 40));
            6: v = 32'h8000_0000 + $urandom_range(0, 3);
            7: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            8: begin
                p = 1;
                repeat ($urandom_range(1, 31)) begin
                    if (p * radix_now <= 64'h7FFF_FFFF) p = p * radix_now;
                end
                p = p + $urandom_range(0, 2) - 1;
                v = p[31:0];
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            default: begin
                v = $urandom() >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [31:0] v, input string text);
        int         gap;
        text_char_t c;
        s_axis_tdata  <= v;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        if (text.len() == 0) begin
            predict_text(v, radix_now);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                c.out_char  = text[i];
                c.last_char = (i == text.len() - 1);
                expected_chars.push_back(c);
            end
        end
        gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_chars.size() != 0 || !s_axis_tready);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == RADIX_ADDR) radix_now = clamp_radix(data);
        // read back the base register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= RADIX_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {26'd0, radix_now}) begin
            $error("prdata: expected %0d, actual %0d", radix_now, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // check every character request against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_chars.size() == 0) begin
                $error("out_char: no request expected, actual %h", m_axis_tdata);
                errors++;
            end else begin
                if (m_axis_tdata !== expected_chars[0].out_char) begin
                    $error("out_char: expected %h, actual %h",
                           expected_chars[0].out_char, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== expected_chars[0].last_char) begin
                    $error("last_char: expected %b, actual %b",
                           expected_chars[0].last_char, m_axis_tlast);
                    errors++;
                end
                void'(expected_chars.pop_front());
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("** integer_to_radix_text: FAILED **");
        $finish;
    end

    initial begin
        int g;
        wait (aresetn);
        forever begin
            g = idle_gap();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    initial begin
        stim_row_t   row;
        logic [31:0] data;
        directed_rows = '{
            '{ROW_VALUE, 3'd0, 32'h0000_0000, "0"},
            '{ROW_VALUE, 3'd0, 32'h8000_0000, "-80000000"},
            '{ROW_VALUE, 3'd0, 32'h7FFF_FFFF, "7FFFFFFF"},
            '{ROW_VALUE, 3'd0, 32'hFFFF_FFFF, "-1"},
            '{ROW_VALUE, 3'd0, 32'h0000_00FF, "FF"},
            '{ROW_WRITE, RADIX_ADDR, 32'd0, ""},
            '{ROW_VALUE, 3'd0, 32'h7FFF_FFFF, ""},
            '{ROW_VALUE, 3'd0, 32'h8000_0000, ""},
            '{ROW_VALUE, 3'd0, 32'h0000_0005, ""},
            '{ROW_WRITE, RADIX_ADDR, 32'd63, ""},
            '{ROW_VALUE, 3'd0, 32'd35, "Z"},
            '{ROW_VALUE, 3'd0, 32'd36, "10"},
            '{ROW_VALUE, 3'd0, 32'h8000_0000, ""},
            '{ROW_VALUE, 3'd0, 32'hFFFF_FFFF, "-1"},
            '{ROW_WRITE, RADIX_ADDR, 32'd1, ""},
            '{ROW_WRITE, UNUSED_ADDR, 32'd10, ""},
            '{ROW_VALUE, 3'd0, 32'd10, "1010"},
            '{ROW_WRITE, RADIX_ADDR, 32'd10, ""},
            '{ROW_VALUE, 3'd0, 32'h8000_0000, "-2147483648"},
            '{ROW_VALUE, 3'd0, 32'h7FFF_FFFF, "2147483647"},
            '{ROW_VALUE, 3'd0, 32'd0, "0"},
            '{ROW_WRITE, RADIX_ADDR, 32'd37, ""},
            '{ROW_VALUE, 3'd0, 32'h7FFF_FFFF, ""},
            '{ROW_VALUE, 3'd0, 32'hFFFF_FFFE, ""}
        };
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                write_register(row.addr, row.data);
            end else begin
                send_value(row.data, row.text);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            no_idle = (phase == 3 || phase == 7);
            case (phase)
                0: data = {26'($urandom_range(0, 67108863)), 6'd2};
                1: data = {26'($urandom_range(0, 67108863)), 6'd36};
                default: data = $urandom();
            endcase
            if ($urandom_range(0, 2) == 0) write_register(UNUSED_ADDR, $urandom());
            write_register(RADIX_ADDR, data);
            repeat (VALUES_PER_PHASE) send_value(pick_value(), "");
        end
        s_axis_tvalid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("** integer_to_radix_text: PASSED **");
        end else begin
            $display("** integer_to_radix_text: FAILED **");
        end
        $finish;
    end

endmodule
